// ----- sv/vdi_pkg.sv -----
// Shared types and constants for the vertex dedup indexer.
// No dependencies; every other file imports this package.
`default_nettype none

package vdi_pkg;

  localparam int unsigned VERTEX_DEPTH = 4096;
  localparam int unsigned ENTRY_LIMIT  = 131072;

  localparam int unsigned VIDX_W     = $clog2(VERTEX_DEPTH);
  localparam int unsigned UCNT_W     = $clog2(VERTEX_DEPTH + 1);
  localparam int unsigned ENTRY_W    = $clog2(ENTRY_LIMIT + 1);
  localparam int unsigned FLOAT_W    = 32;
  localparam int unsigned OUT_IDX_W  = 12;
  localparam int unsigned BATCH_W    = 18;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;

  typedef logic [FLOAT_W-1:0]    float_bits_t;
  typedef logic [VIDX_W-1:0]     vidx_t;
  typedef logic [UCNT_W-1:0]     ucnt_t;
  typedef logic [ENTRY_W-1:0]    entry_cnt_t;
  typedef logic [OUT_IDX_W-1:0]  out_idx_t;
  typedef logic [BATCH_W-1:0]    batch_cnt_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  // Operation codes of the input item
  localparam logic OP_SUBMIT    = 1'b0;
  localparam logic OP_END_BATCH = 1'b1;

  // Configuration register indexes
  localparam cfg_idx_t REG_INDEX_MODE    = cfg_idx_t'(0);
  localparam cfg_idx_t REG_COLOR_ENABLED = cfg_idx_t'(1);
  localparam cfg_idx_t REG_TEX_ENABLED   = cfg_idx_t'(2);

  // One whole vertex as kept in the store
  typedef struct packed {
    float_bits_t x;
    float_bits_t y;
    float_bits_t z;
    float_bits_t red;
    float_bits_t green;
    float_bits_t blue;
    float_bits_t u;
    float_bits_t v;
  } vtx_rec_t;

  // Field groups that take part in equality
  typedef struct packed {
    logic color;
    logic tex;
  } match_en_t;

endpackage

`default_nettype wire

// ----- sv/vdi_in_if.sv -----
// Input channel: valid/ready plus one vertex or end-of-batch item.
// Depends on vdi_pkg.
`default_nettype none

interface vdi_in_if;
  import vdi_pkg::*;

  logic        valid;
  logic        ready;
  logic        op;
  float_bits_t pos_x;
  float_bits_t pos_y;
  float_bits_t pos_z;
  float_bits_t red_bits;
  float_bits_t green_bits;
  float_bits_t blue_bits;
  float_bits_t tex_u;
  float_bits_t tex_v;

  modport source (
    output valid, op, pos_x, pos_y, pos_z, red_bits, green_bits, blue_bits, tex_u, tex_v,
    input  ready
  );
  modport sink (
    input  valid, op, pos_x, pos_y, pos_z, red_bits, green_bits, blue_bits, tex_u, tex_v,
    output ready
  );
endinterface

`default_nettype wire

// ----- sv/vdi_out_if.sv -----
// Result channel: valid/ready plus index, new flag, status and batch count.
// Depends on vdi_pkg.
`default_nettype none

interface vdi_out_if;
  import vdi_pkg::*;

  logic       valid;
  logic       ready;
  out_idx_t   vertex_index;
  logic       is_new;
  logic       status;
  batch_cnt_t batch_entries;

  modport source (
    output valid, vertex_index, is_new, status, batch_entries,
    input  ready
  );
  modport sink (
    input  valid, vertex_index, is_new, status, batch_entries,
    output ready
  );
endinterface

`default_nettype wire

// ----- sv/vdi_cfg_if.sv -----
// Configuration write channel: valid/ready, register index and write data.
// Depends on vdi_pkg.
`default_nettype none

interface vdi_cfg_if;
  import vdi_pkg::*;

  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- sv/vdi_store.sv -----
// Unique vertex store: one write port, one read port with registered data.
// Depends on vdi_pkg.
`default_nettype none

module vdi_store (
  input  logic              clk,
  input  logic              wr_en,
  input  vdi_pkg::vidx_t    wr_addr,
  input  vdi_pkg::vtx_rec_t wr_data,
  input  logic              rd_en,
  input  vdi_pkg::vidx_t    rd_addr,
  output vdi_pkg::vtx_rec_t rd_data
);
  import vdi_pkg::*;

  vtx_rec_t mem [VERTEX_DEPTH];
  vtx_rec_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- sv/vdi_match.sv -----
// Vertex compare unit: float equality of the held item against one stored
// vertex, over the enabled field groups. Depends on vdi_pkg.
`default_nettype none

module vdi_match (
  input  vdi_pkg::vtx_rec_t  item,
  input  vdi_pkg::vtx_rec_t  stored,
  input  vdi_pkg::match_en_t en,
  output logic               equal
);
  import vdi_pkg::*;

  // +0 equals -0, NaN equals nothing
  function automatic logic float_eq(float_bits_t a, float_bits_t b);
    logic a_nan;
    logic b_nan;
    logic zeros;
    a_nan = (a[FLOAT_W-2:0] > 31'h7F80_0000);
    b_nan = (b[FLOAT_W-2:0] > 31'h7F80_0000);
    zeros = ((a[FLOAT_W-2:0] | b[FLOAT_W-2:0]) == '0);
    return !a_nan && !b_nan && ((a == b) || zeros);
  endfunction

  logic pos_eq;
  logic color_eq;
  logic tex_eq;

  always_comb begin
    pos_eq   = float_eq(item.x, stored.x) && float_eq(item.y, stored.y) &&
               float_eq(item.z, stored.z);
    color_eq = float_eq(item.red, stored.red) && float_eq(item.green, stored.green) &&
               float_eq(item.blue, stored.blue);
    tex_eq   = float_eq(item.u, stored.u) && float_eq(item.v, stored.v);
    equal    = pos_eq && (!en.color || color_eq) && (!en.tex || tex_eq);
  end

endmodule

`default_nettype wire

// ----- sv/vertex_dedup_indexer.sv -----
// Top level: sequencer, counters, configuration registers and result register.
// Depends on vdi_pkg, the channel interfaces, vdi_store and vdi_match.
//
//   channel | dir | moves
//   --------+-----+-------------------------------------------------------
//   in_ch   | in  | op, pos_x/y/z, red/green/blue_bits, tex_u/v
//   out_ch  | out | vertex_index, is_new, status, batch_entries
//   cfg_ch  | in  | index, data (bit 0 used); always ready
//
// One item at a time. End of batch or a full entry count: the result goes from
// ST_DECIDE into the output register; index mode off: through ST_INSERT. With
// index mode on, the scan reads one stored vertex per cycle through the store's
// single read port until a hit, or until all stored vertices miss and ST_INSERT follows.
// in_ch.ready is high only while idle; a result waits in the output register
// until transferred. rst_n is synchronous; the store itself is not cleared.
`default_nettype none

module vertex_dedup_indexer (
  input  logic      clk,
  input  logic      rst_n,
  vdi_in_if.sink    in_ch,
  vdi_out_if.source out_ch,
  vdi_cfg_if.sink   cfg_ch
);
  import vdi_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_DECIDE = 5'b00010,
    ST_SCAN   = 5'b00100,
    ST_INSERT = 5'b01000,
    ST_RESP   = 5'b10000
  } state_t;

  state_t     state_r, state_nxt;
  ucnt_t      unique_count_r, unique_count_nxt;
  entry_cnt_t entry_total_r, entry_total_nxt;
  logic       index_mode_r, color_enabled_r, tex_enabled_r;
  vtx_rec_t   item_r, item_nxt;
  logic       op_r, op_nxt;
  ucnt_t      issue_idx_r, issue_idx_nxt;
  vidx_t      cmp_idx_r, cmp_idx_nxt;
  logic       cmp_v_r, cmp_v_nxt;
  out_idx_t   vertex_index_r, vertex_index_nxt;
  logic       is_new_r, is_new_nxt;
  logic       status_r, status_nxt;
  batch_cnt_t batch_entries_r, batch_entries_nxt;

  logic       wr_en;
  logic       rd_en;
  vtx_rec_t   rd_data;
  logic       equal;
  logic       hit;
  match_en_t  match_en;

  assign match_en = '{color: color_enabled_r, tex: tex_enabled_r};

  vdi_store u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (unique_count_r[VIDX_W-1:0]),
    .wr_data (item_r),
    .rd_en   (rd_en),
    .rd_addr (issue_idx_r[VIDX_W-1:0]),
    .rd_data (rd_data)
  );

  vdi_match u_match (
    .item   (item_r),
    .stored (rd_data),
    .en     (match_en),
    .equal  (equal)
  );

  assign hit = cmp_v_r && equal;

  assign in_ch.ready          = (state_r == ST_IDLE);
  assign out_ch.valid         = (state_r == ST_RESP);
  assign out_ch.vertex_index  = vertex_index_r;
  assign out_ch.is_new        = is_new_r;
  assign out_ch.status        = status_r;
  assign out_ch.batch_entries = batch_entries_r;
  assign cfg_ch.ready         = 1'b1;

  always_comb begin
    state_nxt         = state_r;
    unique_count_nxt  = unique_count_r;
    entry_total_nxt   = entry_total_r;
    item_nxt          = item_r;
    op_nxt            = op_r;
    issue_idx_nxt     = issue_idx_r;
    cmp_idx_nxt       = cmp_idx_r;
    cmp_v_nxt         = 1'b0;
    vertex_index_nxt  = vertex_index_r;
    is_new_nxt        = is_new_r;
    status_nxt        = status_r;
    batch_entries_nxt = batch_entries_r;
    wr_en             = 1'b0;
    rd_en             = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          op_nxt         = in_ch.op;
          item_nxt.x     = in_ch.pos_x;
          item_nxt.y     = in_ch.pos_y;
          item_nxt.z     = in_ch.pos_z;
          item_nxt.red   = in_ch.red_bits;
          item_nxt.green = in_ch.green_bits;
          item_nxt.blue  = in_ch.blue_bits;
          item_nxt.u     = in_ch.tex_u;
          item_nxt.v     = in_ch.tex_v;
          state_nxt      = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        vertex_index_nxt  = '0;
        is_new_nxt        = 1'b0;
        status_nxt        = 1'b0;
        batch_entries_nxt = '0;
        issue_idx_nxt     = '0;
        if (op_r == OP_END_BATCH) begin
          batch_entries_nxt = BATCH_W'(entry_total_r);
          unique_count_nxt  = '0;
          entry_total_nxt   = '0;
          state_nxt         = ST_RESP;
        end else if (entry_total_r >= ENTRY_W'(ENTRY_LIMIT)) begin
          status_nxt = 1'b1;
          state_nxt  = ST_RESP;
        end else if (index_mode_r) begin
          state_nxt = ST_SCAN;
        end else begin
          state_nxt = ST_INSERT;
        end
      end

      // Read of entry k is issued in the cycle before it is compared
      ST_SCAN: begin
        if (hit) begin
          vertex_index_nxt = OUT_IDX_W'(cmp_idx_r);
          entry_total_nxt  = entry_total_r + 1'b1;
          state_nxt        = ST_RESP;
        end else if (issue_idx_r == unique_count_r) begin
          state_nxt = ST_INSERT;
        end else begin
          rd_en         = 1'b1;
          cmp_v_nxt     = 1'b1;
          cmp_idx_nxt   = issue_idx_r[VIDX_W-1:0];
          issue_idx_nxt = issue_idx_r + 1'b1;
        end
      end

      ST_INSERT: begin
        if (unique_count_r >= UCNT_W'(VERTEX_DEPTH)) begin
          status_nxt = 1'b1;
        end else begin
          wr_en            = 1'b1;
          vertex_index_nxt = OUT_IDX_W'(unique_count_r);
          is_new_nxt       = 1'b1;
          unique_count_nxt = unique_count_r + 1'b1;
          entry_total_nxt  = entry_total_r + 1'b1;
        end
        state_nxt = ST_RESP;
      end

      ST_RESP: begin
        if (out_ch.ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      unique_count_r <= '0;
      entry_total_r  <= '0;
      cmp_v_r        <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      unique_count_r <= unique_count_nxt;
      entry_total_r  <= entry_total_nxt;
      cmp_v_r        <= cmp_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r          <= item_nxt;
    op_r            <= op_nxt;
    issue_idx_r     <= issue_idx_nxt;
    cmp_idx_r       <= cmp_idx_nxt;
    vertex_index_r  <= vertex_index_nxt;
    is_new_r        <= is_new_nxt;
    status_r        <= status_nxt;
    batch_entries_r <= batch_entries_nxt;
  end

  // Unknown register indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      index_mode_r    <= 1'b0;
      color_enabled_r <= 1'b0;
      tex_enabled_r   <= 1'b0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_INDEX_MODE:    index_mode_r    <= cfg_ch.data[0];
        REG_COLOR_ENABLED: color_enabled_r <= cfg_ch.data[0];
        REG_TEX_ENABLED:   tex_enabled_r   <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for vertex_dedup_indexer: directed table and random
// batches, each result checked against a table value or an in-bench model of the dedup index.
// Depends on vdi_pkg, vdi_in_if, vdi_out_if, vdi_cfg_if and the vertex_dedup_indexer RTL.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import vdi_pkg::*;

  localparam float_bits_t F_POS_ZERO   = 32'h0000_0000;
  localparam float_bits_t F_NEG_ZERO   = 32'h8000_0000;
  localparam float_bits_t F_QNAN       = 32'h7FC0_0000;
  localparam float_bits_t F_ALL_ONES   = 32'hFFFF_FFFF;
  localparam float_bits_t F_POS_INF    = 32'h7F80_0000;
  localparam float_bits_t F_NEG_INF    = 32'hFF80_0000;
  localparam float_bits_t F_ONE        = 32'h3F80_0000;
  localparam float_bits_t F_HALF       = 32'h3F00_0000;
  localparam float_bits_t F_MIN_DENORM = 32'h0000_0001;
  localparam float_bits_t F_MAX_FINITE = 32'h7F7F_FFFF;

  localparam logic ST_OK      = 1'b0;
  localparam logic ST_REFUSED = 1'b1;

  // indexes past the register file; writes there must be dropped
  localparam cfg_idx_t REG_UNUSED_LO = cfg_idx_t'(3);
  localparam cfg_idx_t REG_UNUSED_HI = cfg_idx_t'(8'hFF);

  localparam int unsigned RANDOM_PHASES  = 5;
  localparam int unsigned ITEMS_PER_PHASE = 24;

  typedef struct packed {
    logic     op;
    vtx_rec_t vtx;
  } vdi_item_t;

  typedef struct packed {
    out_idx_t   vertex_index;
    logic       is_new;
    logic       status;
    batch_cnt_t batch_entries;
  } vdi_result_t;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    cfg_idx_t    reg_idx;
    cfg_data_t   reg_data;
    vdi_item_t   item;
    bit          checked;
    vdi_result_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  vdi_in_if  in_ch ();
  vdi_out_if out_ch ();
  vdi_cfg_if cfg_ch ();

  vertex_dedup_indexer i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---- dedup index model ----
  vtx_rec_t    vtx_store [VERTEX_DEPTH];
  int unsigned n_unique;
  int unsigned n_entries;
  logic        mode_index, mode_color, mode_tex;

  vdi_result_t awaited_results [$];
  stim_row_t   directed_rows [$];
  int unsigned mismatches;
  bit          idle_on = 1'b1;
  bit          item_offered;
  bit          reg_offered;

  function automatic bit is_nan(float_bits_t f);
    return f[30:0] > 31'h7F80_0000;
  endfunction

  // +0 == -0, NaN equals nothing
  function automatic bit float_same(float_bits_t a, float_bits_t b);
    if (is_nan(a) || is_nan(b)) return 1'b0;
    if (a == b) return 1'b1;
    return ((a | b) & 32'h7FFF_FFFF) == '0;
  endfunction

  function automatic bit vertex_same(vtx_rec_t a, vtx_rec_t s);
    if (!float_same(a.x, s.x) || !float_same(a.y, s.y) || !float_same(a.z, s.z))
      return 1'b0;
    if (mode_color && (!float_same(a.red, s.red) || !float_same(a.green, s.green) ||
                       !float_same(a.blue, s.blue)))
      return 1'b0;
    if (mode_tex && (!float_same(a.u, s.u) || !float_same(a.v, s.v)))
      return 1'b0;
    return 1'b1;
  endfunction

  function automatic vdi_result_t index_vertex(vdi_item_t it);
    vdi_result_t r;
    r = '0;
    if (it.op == OP_END_BATCH) begin
      r.batch_entries = batch_cnt_t'(n_entries);
      n_unique = 0;
      n_entries = 0;
      return r;
    end
    if (n_entries >= ENTRY_LIMIT) begin
      r.status = ST_REFUSED;
      return r;
    end
    if (mode_index) begin
      for (int i = 0; i < n_unique; i++) begin
        if (vertex_same(it.vtx, vtx_store[i])) begin
          n_entries++;
          r.vertex_index = out_idx_t'(i);
          return r;
        end
      end
    end
    if (n_unique >= VERTEX_DEPTH) begin
      r.status = ST_REFUSED;
      return r;
    end
    vtx_store[n_unique] = it.vtx;
    r.vertex_index = out_idx_t'(n_unique);
    r.is_new = 1'b1;
    n_unique++;
    n_entries++;
    return r;
  endfunction

  // ---- stimulus helpers ----
  function automatic vdi_result_t outcome(int unsigned idx, logic fresh, logic st,
                                          int unsigned batch);
    vdi_result_t r;
    r.vertex_index = out_idx_t'(idx);
    r.is_new = fresh;
    r.status = st;
    r.batch_entries = batch_cnt_t'(batch);
    return r;
  endfunction

  function automatic vdi_item_t make_item(logic op, vtx_rec_t v);
    vdi_item_t it;
    it.op = op;
    it.vtx = v;
    return it;
  endfunction

  function automatic void add_item(logic op, vtx_rec_t v, bit chk, vdi_result_t want);
    stim_row_t row;
    row.kind = ROW_ITEM;
    row.reg_idx = '0;
    row.reg_data = '0;
    row.item = make_item(op, v);
    row.checked = chk;
    row.want = want;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_reg(cfg_idx_t idx, cfg_data_t data);
    stim_row_t row;
    row.kind = ROW_REG;
    row.reg_idx = idx;
    row.reg_data = data;
    row.item = '0;
    row.checked = 1'b0;
    row.want = '0;
    directed_rows.push_back(row);
  endfunction

  // only bit 0 matters; upper bits get noise
  function automatic cfg_data_t reg_word(logic b);
    cfg_data_t w;
    w = $urandom();
    w[0] = b;
    return w;
  endfunction

  function automatic float_bits_t random_float();
    float_bits_t f;
    f = $urandom();
    case ($urandom_range(0, 7))
      0: f = F_POS_ZERO;
      1: f = F_NEG_ZERO;
      2: f[30:23] = '1;  // NaN, or infinity when the mantissa is zero
      3: f = F_POS_INF;
      4: f = F_NEG_INF;
      5: f = F_ONE;
      default: ;
    endcase
    return f;
  endfunction

  function automatic vtx_rec_t random_vertex();
    vtx_rec_t v;
    for (int k = 0; k < 8; k++) v[k*FLOAT_W +: FLOAT_W] = random_float();
    return v;
  endfunction

  // mostly repeats of stored vertices with sign-of-zero and color or texture changes
  function automatic vdi_item_t draw_item();
    vdi_item_t   it;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    it = make_item(OP_SUBMIT, random_vertex());
    if (pick < 8) begin
      it.op = OP_END_BATCH;
    end else if (pick < 62 && n_unique != 0) begin
      it.vtx = vtx_store[$urandom_range(0, n_unique - 1)];
      for (int k = 0; k < 8; k++)
        if (it.vtx[k*FLOAT_W +: FLOAT_W-1] == '0 && $urandom_range(0, 1) == 1)
          it.vtx[k*FLOAT_W + FLOAT_W-1] = ~it.vtx[k*FLOAT_W + FLOAT_W-1];
      if ($urandom_range(0, 2) == 0) begin
        it.vtx.red = random_float();
        it.vtx.green = random_float();
        it.vtx.blue = random_float();
      end
      if ($urandom_range(0, 2) == 0) begin
        it.vtx.u = random_float();
        it.vtx.v = random_float();
      end
    end
    return it;
  endfunction

  // ---- drivers ----
  task automatic stop_items();
    if (item_offered) begin
      in_ch.valid <= 1'b0;
      item_offered = 1'b0;
    end
  endtask

  task automatic drain_results();
    stop_items();
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic send_item(vdi_item_t it, bit checked, vdi_result_t want);
    int unsigned gap;
    vdi_result_t predicted;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (reg_offered) begin
      cfg_ch.valid <= 1'b0;
      reg_offered = 1'b0;
    end
    if (gap != 0) begin
      stop_items();
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.op         <= it.op;
    in_ch.pos_x      <= it.vtx.x;
    in_ch.pos_y      <= it.vtx.y;
    in_ch.pos_z      <= it.vtx.z;
    in_ch.red_bits   <= it.vtx.red;
    in_ch.green_bits <= it.vtx.green;
    in_ch.blue_bits  <= it.vtx.blue;
    in_ch.tex_u      <= it.vtx.u;
    in_ch.tex_v      <= it.vtx.v;
    item_offered = 1'b1;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    predicted = index_vertex(it);
    awaited_results.push_back(checked ? want : predicted);
  endtask

  // registers change only with the block idle
  task automatic write_reg(cfg_idx_t idx, cfg_data_t data);
    drain_results();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    reg_offered = 1'b1;
    @(posedge clk);
    while (cfg_ch.ready !== 1'b1) @(posedge clk);
    case (idx)
      REG_INDEX_MODE:    mode_index = data[0];
      REG_COLOR_ENABLED: mode_color = data[0];
      REG_TEX_ENABLED:   mode_tex   = data[0];
      default: ;
    endcase
  endtask

  // ---- result checking ----
  task automatic note_error(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%t: %s", $realtime, msg);
  endtask

  task automatic check_result();
    vdi_result_t want;
    if (awaited_results.size() == 0) begin
      note_error($sformatf("unexpected result: idx %0d new %0b status %0b batch %0d",
                           out_ch.vertex_index, out_ch.is_new, out_ch.status,
                           out_ch.batch_entries));
      return;
    end
    want = awaited_results.pop_front();
    if (out_ch.vertex_index !== want.vertex_index || out_ch.is_new !== want.is_new ||
        out_ch.status !== want.status || out_ch.batch_entries !== want.batch_entries)
      note_error($sformatf({"mismatch: expected idx %0d new %0b status %0b batch %0d,",
                            " got idx %0d new %0b status %0b batch %0d"},
                           want.vertex_index, want.is_new, want.status, want.batch_entries,
                           out_ch.vertex_index, out_ch.is_new, out_ch.status,
                           out_ch.batch_entries));
  endtask

  // result side: after each result, ready drops for a random hold that counts down only while a result is waiting
  initial begin
    int unsigned hold;
    hold = 0;
    out_ch.ready = 1'b1;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        check_result();
        hold = idle_on ? $urandom_range(0, 3) : 0;
        out_ch.ready <= (hold == 0);
      end else if (out_ch.valid === 1'b1 && hold != 0) begin
        hold--;
        out_ch.ready <= (hold == 0);
      end
    end
  end

  initial begin
    #100_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    vtx_rec_t v_zero, v_ones, v_negz, v_nanx, va, va2, vb, vb2, vc, vtmp;
    logic [2:0] setting;

    n_unique = 0;
    n_entries = 0;
    mode_index = 1'b0;
    mode_color = 1'b0;
    mode_tex = 1'b0;
    mismatches = 0;
    item_offered = 1'b0;
    reg_offered = 1'b0;

    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.op = OP_SUBMIT;
    in_ch.pos_x = '0;
    in_ch.pos_y = '0;
    in_ch.pos_z = '0;
    in_ch.red_bits = '0;
    in_ch.green_bits = '0;
    in_ch.blue_bits = '0;
    in_ch.tex_u = '0;
    in_ch.tex_v = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;

    v_zero = '0;
    v_ones = '1;
    v_negz = {F_NEG_ZERO, F_NEG_ZERO, F_NEG_ZERO, F_ONE, F_ALL_ONES, F_NEG_INF,
              F_POS_ZERO, F_NEG_ZERO};
    v_nanx = {F_QNAN, F_POS_ZERO, F_POS_ZERO, F_POS_ZERO, F_POS_ZERO, F_POS_ZERO,
              F_POS_ZERO, F_POS_ZERO};
    va = {F_POS_INF, F_NEG_INF, F_MAX_FINITE, F_ONE, F_POS_ZERO, F_NEG_ZERO,
          F_HALF, F_MIN_DENORM};
    va2 = va;
    va2.red = F_NEG_INF;
    va2.green = F_ONE;
    va2.blue = F_ONE;
    va2.u = F_ONE;
    va2.v = F_ONE;
    vb = va;
    vb.red = F_HALF;
    vb.green = F_HALF;
    vb.blue = F_HALF;
    vb2 = vb;
    vb2.u = F_QNAN;
    vb2.v = F_ALL_ONES;
    vc = vb;
    vc.u = F_NEG_ZERO;
    vc.v = F_MAX_FINITE;

    // registers at reset: every vertex is new
    add_item(OP_SUBMIT, v_zero, 1'b1, outcome(0, 1'b1, ST_OK, 0));
    add_item(OP_SUBMIT, v_ones, 1'b1, outcome(1, 1'b1, ST_OK, 0));
    add_item(OP_SUBMIT, v_zero, 1'b1, outcome(2, 1'b1, ST_OK, 0));
    add_item(OP_END_BATCH, v_ones, 1'b1, outcome(0, 1'b0, ST_OK, 3));
    add_reg(REG_UNUSED_LO, '1);
    add_reg(REG_UNUSED_HI, cfg_data_t'(1));
    add_item(OP_SUBMIT, v_zero, 1'b1, outcome(0, 1'b1, ST_OK, 0));
    add_reg(REG_INDEX_MODE, 32'hFFFF_FFFE);
    add_item(OP_SUBMIT, v_zero, 1'b1, outcome(1, 1'b1, ST_OK, 0));
    add_reg(REG_INDEX_MODE, cfg_data_t'(1));
    add_item(OP_SUBMIT, v_negz, 1'b1, outcome(0, 1'b0, ST_OK, 0));  // -0 hits +0
    add_item(OP_SUBMIT, v_nanx, 1'b1, outcome(2, 1'b1, ST_OK, 0));
    add_item(OP_SUBMIT, v_nanx, 1'b1, outcome(3, 1'b1, ST_OK, 0));  // NaN never hits
    add_item(OP_SUBMIT, va, 1'b1, outcome(4, 1'b1, ST_OK, 0));
    add_item(OP_SUBMIT, va2, 1'b1, outcome(4, 1'b0, ST_OK, 0));
    add_reg(REG_COLOR_ENABLED, cfg_data_t'(1));
    add_item(OP_SUBMIT, vb, 1'b1, outcome(5, 1'b1, ST_OK, 0));
    add_item(OP_SUBMIT, vb2, 1'b0, '0);
    add_reg(REG_TEX_ENABLED, cfg_data_t'(1));
    add_item(OP_SUBMIT, vc, 1'b0, '0);
    vtmp = vc;
    vtmp.u = F_POS_ZERO;
    add_item(OP_SUBMIT, vtmp, 1'b0, '0);
    vtmp = vc;
    vtmp.v = F_QNAN;
    add_item(OP_SUBMIT, vtmp, 1'b0, '0);
    add_reg(REG_COLOR_ENABLED, cfg_data_t'(0));
    vtmp = vc;
    vtmp.red = F_ALL_ONES;
    add_item(OP_SUBMIT, vtmp, 1'b0, '0);
    add_item(OP_END_BATCH, v_zero, 1'b0, '0);
    add_item(OP_SUBMIT, v_ones, 1'b1, outcome(0, 1'b1, ST_OK, 0));
    add_item(OP_END_BATCH, v_zero, 1'b1, outcome(0, 1'b0, ST_OK, 1));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_REG) begin
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_data);
      end else begin
        send_item(directed_rows[i].item, directed_rows[i].checked, directed_rows[i].want);
      end
    end

    // random batches under several register settings
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: setting = 3'b111;
        1: setting = 3'b100;
        2: setting = 3'b101;
        3: setting = 3'b011;
        default: setting = 3'($urandom());
      endcase
      write_reg(REG_INDEX_MODE, reg_word(setting[2]));
      write_reg(REG_COLOR_ENABLED, reg_word(setting[1]));
      write_reg(REG_TEX_ENABLED, reg_word(setting[0]));
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(0, 39) == 0) drain_results();  // sender holds off until drained
        send_item(draw_item(), 1'b0, '0);
      end
    end

    drain_results();
    if (reg_offered) begin
      cfg_ch.valid <= 1'b0;
      reg_offered = 1'b0;
    end
    repeat (20) @(posedge clk);

    if (awaited_results.size() != 0) begin
      $display("%0d results never arrived", awaited_results.size());
      mismatches += awaited_results.size();
    end
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
